FILE: hdl/apmt_pkg.sv
`timescale 1ns / 1ps
package apmt_pkg;

	localparam int ANCHOR_W   = 8;
	localparam int ANCHOR_IDS = 256;
	localparam int DIST_W     = 9;
	localparam int DIFF_W     = 32;
	localparam int TIME_W     = 32;
	localparam int AGE_W      = 16;
	localparam int REMOVED_W  = 7;
	localparam int COUNT_W    = 7;
	localparam int SEEN_W     = 8;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 32;

	localparam logic [AGE_W-1:0] STALE_RESET = 16'd350;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_SWEEP = 1'b1;

	localparam logic [DIFF_W-1:0] DIFF_MIN = 32'h8000_0000;
	localparam logic [DIFF_W-1:0] DIFF_MAX = 32'h7FFF_FFFF;

	// one table entry as stored in the entry memory
	typedef struct packed {
		logic [TIME_W-1:0]   stamp;
		logic [DIFF_W-1:0]   value;
		logic [ANCHOR_W-1:0] second;
		logic [ANCHOR_W-1:0] first;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// reference count request toward the anchor counter
	typedef struct packed {
		logic                valid;
		logic                inc;
		logic [ANCHOR_W-1:0] id;
	} anc_req_t;

	// anchor counter status
	typedef struct packed {
		logic              ready;
		logic [DIST_W-1:0] distinct;
	} anc_stat_t;

	// negate with saturation of the most negative value
	function automatic logic [DIFF_W-1:0] sat_neg(input logic [DIFF_W-1:0] v);
		logic [DIFF_W-1:0] r;
		if (v == DIFF_MIN) begin
			r = DIFF_MAX;
		end else begin
			r = DIFF_W'(0) - v;
		end
		return r;
	endfunction

	// clamp a count to a 7 bit field
	function automatic logic [COUNT_W-1:0] sat_count(input logic [DIST_W-1:0] v);
		logic [COUNT_W-1:0] r;
		if (v > DIST_W'((1 << COUNT_W) - 1)) begin
			r = '1;
		end else begin
			r = v[COUNT_W-1:0];
		end
		return r;
	endfunction

	// clamp the distinct anchor count to an 8 bit field
	function automatic logic [SEEN_W-1:0] sat_seen(input logic [DIST_W-1:0] v);
		logic [SEEN_W-1:0] r;
		if (v > DIST_W'((1 << SEEN_W) - 1)) begin
			r = '1;
		end else begin
			r = v[SEEN_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/apmt_ram.sv
`timescale 1ns / 1ps
module apmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: hdl/apmt_anchor_count.sv
`timescale 1ns / 1ps
module apmt_anchor_count import apmt_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  anc_req_t  req,
	output anc_stat_t stat
);

	// each entry references two anchor ids
	localparam int RCW = $clog2(2 * TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD
	} state_t;

	state_t              state_q;
	logic [ANCHOR_W-1:0] clr_idx_q;
	logic [ANCHOR_W-1:0] id_q;
	logic                inc_q;
	logic [DIST_W-1:0]   distinct_q;

	logic                ram_we;
	logic [ANCHOR_W-1:0] ram_wr_addr;
	logic [RCW-1:0]      ram_wr_data;
	logic [ANCHOR_W-1:0] ram_rd_addr;
	logic [RCW-1:0]      ram_rd_data;
	logic [RCW-1:0]      cnt_next;

	// shared increment / decrement of the fetched count
	assign cnt_next = inc_q ? (ram_rd_data + RCW'(1)) : (ram_rd_data - RCW'(1));

	assign ram_rd_addr = (state_q == ST_IDLE) ? req.id : id_q;

	// write side: clearing pass or read-modify-write
	always_comb begin
		ram_we      = 1'b0;
		ram_wr_addr = id_q;
		ram_wr_data = cnt_next;
		case (state_q)
			ST_CLEAR: begin
				ram_we      = 1'b1;
				ram_wr_addr = clr_idx_q;
				ram_wr_data = '0;
			end
			ST_UPD: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	apmt_ram #(
		.WIDTH(RCW),
		.DEPTH(ANCHOR_IDS)
	) u_ref_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// sequencer and distinct id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_idx_q  <= '0;
			id_q       <= '0;
			inc_q      <= 1'b0;
			distinct_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + ANCHOR_W'(1);
					if (clr_idx_q == ANCHOR_W'(ANCHOR_IDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						id_q    <= req.id;
						inc_q   <= req.inc;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (inc_q && (ram_rd_data == '0)) begin
						distinct_q <= distinct_q + DIST_W'(1);
					end else if (!inc_q && (ram_rd_data == RCW'(1))) begin
						distinct_q <= distinct_q - DIST_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.ready    = (state_q == ST_IDLE);
	assign stat.distinct = distinct_q;

endmodule

FILE: hdl/anchor_pair_measurement_table.sv
`timescale 1ns / 1ps
// channel   dir  signals                          request
// s_*       in   tvalid tready tdata[79:0] tuser  one measurement or sweep
// m_*       out  tvalid tready tdata[31:0]        one result per request
// cfg_*     in   wr_en wr_data[15:0]              stale age limit write
//
// After reset a clearing pass over all 256 anchor reference counts runs;
// s_tready stays low until it ends.
// A store scans the table with one entry memory read per cycle; when a new
// entry is inserted, two anchor reference count updates follow.
// A sweep scans the same way and pauses at each removed entry for two
// read-modify-write updates of the anchor reference counts.
// One request at a time; a waiting result does not block acceptance of the next.
module anchor_pair_measurement_table import apmt_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// anchor_first, anchor_second, distance_diff, now_ms
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// stored, was_update, dropped_full, removed_count, entry_count,
	// anchor_ids, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_wr_en,
	input  logic [AGE_W-1:0]      cfg_wr_data
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DEC_FIRST,
		S_DEC_SECOND,
		S_DECIDE,
		S_INC_FIRST,
		S_INC_SECOND,
		S_RESULT
	} state_t;

	state_t                  state_q;
	logic [AGE_W-1:0]        stale_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CW-1:0]           live_q;
	logic [CW-1:0]           removed_q;

	logic                    op_q;
	logic [ANCHOR_W-1:0]     a_q;
	logic [ANCHOR_W-1:0]     b_q;
	logic [DIFF_W-1:0]       diff_q;
	logic [TIME_W-1:0]       now_q;

	logic [IW:0]             scan_idx_q;
	logic                    chk_vld_s1;
	logic [IW-1:0]           chk_idx_s1;

	logic                    hit_found_q;
	logic [IW-1:0]           hit_idx_q;
	logic [ANCHOR_W-1:0]     hit_first_q;
	logic [ANCHOR_W-1:0]     hit_second_q;
	logic                    free_found_q;
	logic [IW-1:0]           free_idx_q;
	logic [ANCHOR_W-1:0]     rm_first_q;
	logic [ANCHOR_W-1:0]     rm_second_q;

	logic                    stored_q;
	logic                    upd_q;
	logic                    drop_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;

	entry_t                  rd_entry;
	logic [ENTRY_W-1:0]      ram_rd_data;
	logic                    ram_we;
	logic [IW-1:0]           ram_wr_addr;
	entry_t                  ram_wr_entry;
	logic                    issue_more;
	logic                    chk_valid;
	logic                    pair_match;
	logic                    is_stale;
	logic [TIME_W-1:0]       age;
	logic [DIFF_W-1:0]       upd_value;
	anc_req_t                anc_req;
	anc_stat_t               anc_stat;

	// entry memory: anchors, value and stamp per slot
	apmt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_entry),
		.rd_addr(scan_idx_q[IW-1:0]),
		.rd_data(ram_rd_data)
	);

	apmt_anchor_count #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_anchor_count (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (anc_req),
		.stat  (anc_stat)
	);

	// compare of the entry fetched last cycle
	assign rd_entry   = entry_t'(ram_rd_data);
	assign issue_more = (scan_idx_q != (IW + 1)'(TABLE_ENTRIES));
	assign chk_valid  = valid_q[chk_idx_s1];
	assign pair_match = ((rd_entry.first == a_q) && (rd_entry.second == b_q)) ||
	                    ((rd_entry.first == b_q) && (rd_entry.second == a_q));
	assign age        = now_q - rd_entry.stamp;
	assign is_stale   = (age > TIME_W'(stale_q));
	assign upd_value  = (a_q == hit_second_q) ? sat_neg(diff_q) : diff_q;

	// entry write on update or insert
	always_comb begin
		ram_we       = 1'b0;
		ram_wr_addr  = free_idx_q;
		ram_wr_entry = '{stamp: now_q, value: diff_q, second: b_q, first: a_q};
		if (state_q == S_DECIDE) begin
			if (hit_found_q) begin
				ram_we       = 1'b1;
				ram_wr_addr  = hit_idx_q;
				ram_wr_entry = '{stamp: now_q, value: upd_value,
				                 second: hit_second_q, first: hit_first_q};
			end else if (free_found_q) begin
				ram_we = 1'b1;
			end
		end
	end

	// reference count requests
	always_comb begin
		anc_req = '{valid: 1'b0, inc: 1'b0, id: a_q};
		case (state_q)
			S_DEC_FIRST:  anc_req = '{valid: 1'b1, inc: 1'b0, id: rm_first_q};
			S_DEC_SECOND: anc_req = '{valid: 1'b1, inc: 1'b0, id: rm_second_q};
			S_INC_FIRST:  anc_req = '{valid: 1'b1, inc: 1'b1, id: a_q};
			S_INC_SECOND: anc_req = '{valid: 1'b1, inc: 1'b1, id: b_q};
			default:      anc_req = '{valid: 1'b0, inc: 1'b0, id: a_q};
		endcase
	end

	assign s_tready = (state_q == S_IDLE) && anc_stat.ready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= STALE_RESET;
		end else if (cfg_wr_en) begin
			stale_q <= cfg_wr_data;
		end
	end

	// sequencer, table state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			live_q       <= '0;
			removed_q    <= '0;
			op_q         <= OP_STORE;
			a_q          <= '0;
			b_q          <= '0;
			diff_q       <= '0;
			now_q        <= '0;
			scan_idx_q   <= '0;
			chk_vld_s1   <= 1'b0;
			chk_idx_s1   <= '0;
			hit_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			hit_first_q  <= '0;
			hit_second_q <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			rm_first_q   <= '0;
			rm_second_q  <= '0;
			stored_q     <= 1'b0;
			upd_q        <= 1'b0;
			drop_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q         <= s_tuser;
						a_q          <= s_tdata[7:0];
						b_q          <= s_tdata[15:8];
						diff_q       <= s_tdata[47:16];
						now_q        <= s_tdata[79:48];
						scan_idx_q   <= '0;
						chk_vld_s1   <= 1'b0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						removed_q    <= '0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					// fetch the next entry
					if (issue_more) begin
						chk_vld_s1 <= 1'b1;
						chk_idx_s1 <= scan_idx_q[IW-1:0];
						scan_idx_q <= scan_idx_q + (IW + 1)'(1);
					end else begin
						chk_vld_s1 <= 1'b0;
					end
					// examine the fetched entry
					if (chk_vld_s1) begin
						if (op_q == OP_SWEEP) begin
							if (chk_valid && is_stale) begin
								valid_q[chk_idx_s1] <= 1'b0;
								removed_q           <= removed_q + CW'(1);
								live_q              <= live_q - CW'(1);
								rm_first_q          <= rd_entry.first;
								rm_second_q         <= rd_entry.second;
								scan_idx_q          <= (IW + 1)'(chk_idx_s1) + (IW + 1)'(1);
								chk_vld_s1          <= 1'b0;
								state_q             <= S_DEC_FIRST;
							end
						end else begin
							if (chk_valid && pair_match && !hit_found_q) begin
								hit_found_q  <= 1'b1;
								hit_idx_q    <= chk_idx_s1;
								hit_first_q  <= rd_entry.first;
								hit_second_q <= rd_entry.second;
							end
							if (!chk_valid && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= chk_idx_s1;
							end
						end
					end
					// whole table examined
					if (!issue_more && !chk_vld_s1) begin
						if (op_q == OP_SWEEP) begin
							stored_q <= 1'b0;
							upd_q    <= 1'b0;
							drop_q   <= 1'b0;
							state_q  <= S_RESULT;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DEC_FIRST: begin
					if (anc_stat.ready) begin
						state_q <= S_DEC_SECOND;
					end
				end
				S_DEC_SECOND: begin
					if (anc_stat.ready) begin
						state_q <= S_SCAN;
					end
				end
				S_DECIDE: begin
					if (hit_found_q) begin
						stored_q <= 1'b1;
						upd_q    <= 1'b1;
						drop_q   <= 1'b0;
						state_q  <= S_RESULT;
					end else if (free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
						live_q              <= live_q + CW'(1);
						stored_q            <= 1'b1;
						upd_q               <= 1'b0;
						drop_q              <= 1'b0;
						state_q             <= S_INC_FIRST;
					end else begin
						stored_q <= 1'b0;
						upd_q    <= 1'b0;
						drop_q   <= 1'b1;
						state_q  <= S_RESULT;
					end
				end
				S_INC_FIRST: begin
					if (anc_stat.ready) begin
						state_q <= S_INC_SECOND;
					end
				end
				S_INC_SECOND: begin
					if (anc_stat.ready) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					// wait for the last count update and a free output slot
					if (anc_stat.ready && (!m_tvalid_q || m_tready)) begin
						m_tdata_q  <= {7'd0,
						               sat_seen(anc_stat.distinct),
						               sat_count(DIST_W'(live_q)),
						               sat_count(DIST_W'(removed_q)),
						               drop_q, upd_q, stored_q};
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
